>>> hdl/slmp_pkg.sv
// Shared types, constants and saturating arithmetic for the spin chain stepper.
package slmp_pkg;

	// Fixed-point format: signed Q7.24 in a 32-bit word.
	localparam int VALUE_BITS = 32;
	localparam int FRAC_BITS  = VALUE_BITS - 8;
	localparam int SITE_BITS  = 6;
	localparam int CFG_IDX_BITS = 3;
	localparam int MAX_SITES_DEF = 64;
	// Highest active site number that a step may walk (a 6-bit site field reaches 63).
	localparam int SITE_LIMIT = 62;

	typedef logic signed [VALUE_BITS-1:0] val_t;
	typedef logic [SITE_BITS-1:0] site_t;

	// Request kinds carried on the input tuser.
	typedef enum logic [1:0] {
		REQ_LOAD_SITE = 2'd0,
		REQ_LOAD_CPL  = 2'd1,
		REQ_STEP      = 2'd2
	} req_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_SITE_COUNT  = 3'd0,
		CFG_DRIVE_FIRST = 3'd1,
		CFG_DRIVE_LAST  = 3'd2,
		CFG_BIAS_Z      = 3'd3,
		CFG_HALF_GAIN   = 3'd4,
		CFG_FULL_GAIN   = 3'd5
	} cfg_idx_t;

	// A saturated value together with its overflow mark.
	typedef struct packed {
		logic signed [VALUE_BITS-1:0] v;
		logic o;
	} sres_t;

	localparam val_t VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// Saturating addition.
	function automatic sres_t sat_add(input val_t a, input val_t b);
		logic signed [VALUE_BITS:0] sum;
		sres_t r;
		sum = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
		r.o = sum[VALUE_BITS] != sum[VALUE_BITS-1];
		r.v = r.o ? (sum[VALUE_BITS] ? VAL_MIN : VAL_MAX) : sum[VALUE_BITS-1:0];
		return r;
	endfunction

	// Saturating subtraction.
	function automatic sres_t sat_sub(input val_t a, input val_t b);
		logic signed [VALUE_BITS:0] dif;
		sres_t r;
		dif = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
		r.o = dif[VALUE_BITS] != dif[VALUE_BITS-1];
		r.v = r.o ? (dif[VALUE_BITS] ? VAL_MIN : VAL_MAX) : dif[VALUE_BITS-1:0];
		return r;
	endfunction

endpackage

>>> hdl/slmp_qmul.sv
// Fixed-point multiplier with a registered product, floor rounding and saturation.
module slmp_qmul (
	input  logic           clk,
	input  slmp_pkg::val_t a,
	input  slmp_pkg::val_t b,
	output slmp_pkg::val_t q,
	output logic           ovf
);
	import slmp_pkg::*;

	localparam int PW = 2 * VALUE_BITS;

	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] shifted;
	logic                 fits;

	// Full-width product, registered.
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(a) * PW'(b);
	end

	// Arithmetic shift rounds toward minus infinity; the upper bits must all match the sign.
	always_comb begin
		shifted = prod_s1 >>> FRAC_BITS;
		fits = (&shifted[PW-1:VALUE_BITS-1]) | ~(|shifted[PW-1:VALUE_BITS-1]);
		ovf = ~fits;
		if (fits) begin
			q = shifted[VALUE_BITS-1:0];
		end else if (shifted[PW-1]) begin
			q = VAL_MIN;
		end else begin
			q = VAL_MAX;
		end
	end

endmodule

>>> hdl/spin_chain_llg_midpoint_step.sv
// Top level of the spin chain precession stepper (midpoint Runge-Kutta, Q7.24).
//
// Load words write one site vector or one link coupling. A step word walks the active
// sites twice, first to build the midpoint vectors and then the new vectors, and emits
// one word per site in site order with tlast on the highest active site. Each site in
// each pass takes four reads of the vector and coupling memories, eighteen steps of the
// single shared multiplier, and one write back, which waits on the output in the second
// pass. After reset the block sweeps its site and coupling memories to zero, one entry
// a cycle, and accepts no word until that sweep is done; configuration writes are taken
// at any time.
module spin_chain_llg_midpoint_step #(
	parameter int MAX_SITES = slmp_pkg::MAX_SITES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input word.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// tdata: site, value_x, value_y, value_z, drive_start, drive_mid, zero fill.
	input  logic [167:0]                    s_axis_tdata,
	// tuser: req_type.
	input  logic [1:0]                      s_axis_tuser,
	// Result word.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// tdata: out_site, mag_x, mag_y, mag_z, zero fill.
	output logic [103:0]                    m_axis_tdata,
	// tuser: overflow.
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast,
	// Configuration write.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [slmp_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [slmp_pkg::VALUE_BITS-1:0] cfg_data
);
	import slmp_pkg::*;

	localparam int AW = $clog2(MAX_SITES);
	localparam int LIM = (MAX_SITES - 2 > SITE_LIMIT) ? SITE_LIMIT : MAX_SITES - 2;
	localparam int VW = 3 * VALUE_BITS;

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_LOAD, ST_CALC, ST_WRITE} state_t;

	// Configuration registers.
	site_t site_count_q, drive_first_q, drive_last_q;
	val_t  bias_z_q, half_gain_q, full_gain_q;

	// Sequencer state.
	state_t       state_q;
	logic         pass_q;
	site_t        site_q, n_q;
	logic [4:0]   sub_q;
	logic [AW-1:0] clr_q;
	val_t         drv_start_q, drv_mid_q;

	// Operands and intermediate values.
	val_t jl_q, jr_q, axl_q, ayl_q, azl_q, axr_q, ayr_q, azr_q;
	val_t mx_q, my_q, mz_q, bx_q, by_q, bz_q;
	val_t tmp_q, hx_q, hy_q, hz_q, cx_q, cy_q, cz_q, r0_q, r1_q, r2_q;
	logic mov_q, sat_q;

	// Output register.
	logic         out_valid_q;
	site_t        out_site_q;
	val_t         out_x_q, out_y_q, out_z_q;
	logic         out_last_q, out_ovf_q;

	// Memories.
	logic [VW-1:0]         site_mem [MAX_SITES];
	logic [VW:0]           mid_mem  [MAX_SITES];
	logic [VALUE_BITS-1:0] cpl_mem  [MAX_SITES];
	logic [VW-1:0]         site_rd;
	logic [VW:0]           mid_rd;
	logic [VALUE_BITS-1:0] cpl_rd;
	logic [AW-1:0]         rd_addr, cpl_addr, wr_addr;
	logic                  site_we, mid_we, cpl_we;
	logic [VW-1:0]         site_wd;
	logic [VALUE_BITS-1:0] cpl_wd;

	// Input fields.
	site_t in_site;
	val_t  in_x, in_y, in_z, in_dstart, in_dmid;
	logic  in_ok, in_fire, out_free, drive_on;
	site_t n_clamp;

	// Multiplier.
	val_t mul_a, mul_b, mul_q;
	logic mul_ovf;
	val_t gain, drive;
	val_t a_left_x, a_left_y, a_left_z;

	slmp_qmul u_qmul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.q   (mul_q),
		.ovf (mul_ovf)
	);

	assign in_site   = s_axis_tdata[5:0];
	assign in_x      = s_axis_tdata[37:6];
	assign in_y      = s_axis_tdata[69:38];
	assign in_z      = s_axis_tdata[101:70];
	assign in_dstart = s_axis_tdata[133:102];
	assign in_dmid   = s_axis_tdata[165:134];
	assign in_ok     = 32'(in_site) < 32'(MAX_SITES);
	assign in_fire   = s_axis_tvalid & s_axis_tready;
	assign n_clamp   = (site_count_q > site_t'(LIM)) ? site_t'(LIM) : site_count_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_z_q, out_y_q, out_x_q, out_site_q};
	assign m_axis_tuser  = out_ovf_q;
	assign m_axis_tlast  = out_last_q;
	assign out_free      = ~out_valid_q | m_axis_tready;

	assign gain  = pass_q ? full_gain_q : half_gain_q;
	assign drive = pass_q ? drv_mid_q : drv_start_q;
	assign drive_on = (site_q >= drive_first_q) && (site_q <= drive_last_q);

	// Read addresses walk the left neighbor, the site and the right neighbor.
	always_comb begin
		rd_addr  = AW'(site_q);
		cpl_addr = AW'(site_q);
		if (sub_q == 5'd0) begin
			rd_addr  = AW'(site_q - site_t'(1));
			cpl_addr = AW'(site_q - site_t'(1));
		end else if (sub_q == 5'd2) begin
			rd_addr = AW'(site_q + site_t'(1));
		end
	end

	// Memory write selection: clearing sweep, load words, or write back.
	always_comb begin
		site_we = 1'b0;
		mid_we  = 1'b0;
		cpl_we  = 1'b0;
		wr_addr = AW'(site_q);
		site_wd = {r2_q, r1_q, r0_q};
		cpl_wd  = in_x;
		unique case (state_q)
			ST_CLEAR: begin
				site_we = 1'b1;
				cpl_we  = 1'b1;
				wr_addr = clr_q;
				site_wd = '0;
				cpl_wd  = '0;
			end
			ST_IDLE: begin
				wr_addr = AW'(in_site);
				site_wd = {in_z, in_y, in_x};
				site_we = in_fire && in_ok && (s_axis_tuser == REQ_LOAD_SITE);
				cpl_we  = in_fire && in_ok && (s_axis_tuser == REQ_LOAD_CPL);
			end
			ST_WRITE: begin
				mid_we  = ~pass_q;
				site_we = pass_q & out_free;
			end
			default: begin
			end
		endcase
	end

	// Site vector memory.
	always_ff @(posedge clk) begin
		if (site_we) begin
			site_mem[wr_addr] <= site_wd;
		end
		site_rd <= site_mem[rd_addr];
	end

	// Midpoint memory, with the midpoint overflow mark on top.
	always_ff @(posedge clk) begin
		if (mid_we) begin
			mid_mem[wr_addr] <= {sat_q, r2_q, r1_q, r0_q};
		end
		mid_rd <= mid_mem[rd_addr];
	end

	// Coupling memory.
	always_ff @(posedge clk) begin
		if (cpl_we) begin
			cpl_mem[wr_addr] <= cpl_wd;
		end
		cpl_rd <= cpl_mem[cpl_addr];
	end

	// Vector set that feeds the field: stored sites first, midpoints second.
	always_comb begin
		if (pass_q) begin
			a_left_x = mid_rd[VALUE_BITS-1:0];
			a_left_y = mid_rd[2*VALUE_BITS-1:VALUE_BITS];
			a_left_z = mid_rd[VW-1:2*VALUE_BITS];
		end else begin
			a_left_x = site_rd[VALUE_BITS-1:0];
			a_left_y = site_rd[2*VALUE_BITS-1:VALUE_BITS];
			a_left_z = site_rd[VW-1:2*VALUE_BITS];
		end
	end

	// Multiplier operand schedule.
	always_comb begin
		mul_a = jl_q;
		mul_b = axl_q;
		case (sub_q)
			5'd1:  begin mul_a = jr_q; mul_b = axr_q; end
			5'd2:  begin mul_a = jl_q; mul_b = ayl_q; end
			5'd3:  begin mul_a = jr_q; mul_b = ayr_q; end
			5'd4:  begin mul_a = jl_q; mul_b = azl_q; end
			5'd5:  begin mul_a = jr_q; mul_b = azr_q; end
			5'd8:  begin mul_a = my_q; mul_b = hz_q; end
			5'd9:  begin mul_a = mz_q; mul_b = hy_q; end
			5'd10: begin mul_a = mx_q; mul_b = hz_q; end
			5'd11: begin mul_a = mz_q; mul_b = hx_q; end
			5'd12: begin mul_a = mx_q; mul_b = hy_q; end
			5'd13: begin mul_a = my_q; mul_b = hx_q; end
			5'd14: begin mul_a = gain; mul_b = cx_q; end
			5'd15: begin mul_a = gain; mul_b = cy_q; end
			5'd16: begin mul_a = gain; mul_b = cz_q; end
			default: begin
			end
		endcase
	end

	// Sequencer, configuration and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		sres_t t;
		logic  ovf_acc;
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			pass_q        <= 1'b0;
			site_q        <= '0;
			n_q           <= '0;
			sub_q         <= '0;
			sat_q         <= 1'b0;
			out_valid_q   <= 1'b0;
			site_count_q  <= site_t'(62);
			drive_first_q <= site_t'(1);
			drive_last_q  <= site_t'(3);
			bias_z_q      <= '0;
			half_gain_q   <= '0;
			full_gain_q   <= '0;
		end else begin
			// Configuration writes.
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SITE_COUNT:  site_count_q  <= cfg_data[SITE_BITS-1:0];
					CFG_DRIVE_FIRST: drive_first_q <= cfg_data[SITE_BITS-1:0];
					CFG_DRIVE_LAST:  drive_last_q  <= cfg_data[SITE_BITS-1:0];
					CFG_BIAS_Z:      bias_z_q      <= cfg_data;
					CFG_HALF_GAIN:   half_gain_q   <= cfg_data;
					CFG_FULL_GAIN:   full_gain_q   <= cfg_data;
					default: begin
					end
				endcase
			end

			// A taken word frees the output unless a new one is loaded this cycle.
			if (out_valid_q && m_axis_tready && !((state_q == ST_WRITE) && pass_q)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_SITES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire && (s_axis_tuser == REQ_STEP) && (n_clamp != '0)) begin
						n_q         <= n_clamp;
						drv_start_q <= in_dstart;
						drv_mid_q   <= in_dmid;
						pass_q      <= 1'b0;
						site_q      <= site_t'(1);
						sub_q       <= '0;
						state_q     <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					unique case (sub_q)
						5'd0: begin
							sat_q <= 1'b0;
							sub_q <= sub_q + 5'd1;
						end
						5'd1: begin
							// Left neighbor; site zero reads as zero.
							jl_q  <= cpl_rd;
							axl_q <= (site_q == site_t'(1)) ? '0 : a_left_x;
							ayl_q <= (site_q == site_t'(1)) ? '0 : a_left_y;
							azl_q <= (site_q == site_t'(1)) ? '0 : a_left_z;
							sub_q <= sub_q + 5'd1;
						end
						5'd2: begin
							jr_q  <= cpl_rd;
							mx_q  <= a_left_x;
							my_q  <= a_left_y;
							mz_q  <= a_left_z;
							bx_q  <= site_rd[VALUE_BITS-1:0];
							by_q  <= site_rd[2*VALUE_BITS-1:VALUE_BITS];
							bz_q  <= site_rd[VW-1:2*VALUE_BITS];
							mov_q <= mid_rd[VW];
							sub_q <= sub_q + 5'd1;
						end
						default: begin
							// Right neighbor; sites above the active count read as zero.
							axr_q <= (site_q == n_q) ? '0 : a_left_x;
							ayr_q <= (site_q == n_q) ? '0 : a_left_y;
							azr_q <= (site_q == n_q) ? '0 : a_left_z;
							sub_q <= '0;
							state_q <= ST_CALC;
						end
					endcase
				end
				ST_CALC: begin
					sub_q <= sub_q + 5'd1;
					case (sub_q)
						5'd1, 5'd3, 5'd5, 5'd9, 5'd11, 5'd13: begin
							tmp_q <= mul_q;
							sat_q <= sat_q | mul_ovf;
						end
						5'd2: begin
							t = sat_add(tmp_q, mul_q);
							hx_q <= t.v;
							sat_q <= sat_q | mul_ovf | t.o;
						end
						5'd4: begin
							t = sat_add(tmp_q, mul_q);
							hy_q <= t.v;
							sat_q <= sat_q | mul_ovf | t.o;
						end
						5'd6: begin
							t = sat_add(tmp_q, mul_q);
							hz_q <= t.v;
							ovf_acc = sat_q | mul_ovf | t.o;
							if (drive_on) begin
								t = sat_add(hx_q, drive);
								hx_q <= t.v;
								ovf_acc = ovf_acc | t.o;
							end
							sat_q <= ovf_acc;
						end
						5'd7: begin
							t = sat_add(hz_q, bias_z_q);
							hz_q <= t.v;
							sat_q <= sat_q | t.o;
						end
						5'd10: begin
							t = sat_sub(tmp_q, mul_q);
							cx_q <= t.v;
							sat_q <= sat_q | mul_ovf | t.o;
						end
						5'd12: begin
							t = sat_sub(tmp_q, mul_q);
							cy_q <= t.v;
							sat_q <= sat_q | mul_ovf | t.o;
						end
						5'd14: begin
							t = sat_sub(tmp_q, mul_q);
							cz_q <= t.v;
							sat_q <= sat_q | mul_ovf | t.o;
						end
						5'd15: begin
							t = sat_sub(bx_q, mul_q);
							r0_q <= t.v;
							sat_q <= sat_q | mul_ovf | t.o;
						end
						5'd16: begin
							t = sat_add(by_q, mul_q);
							r1_q <= t.v;
							sat_q <= sat_q | mul_ovf | t.o;
						end
						5'd17: begin
							t = sat_sub(bz_q, mul_q);
							r2_q <= t.v;
							sat_q <= sat_q | mul_ovf | t.o;
							state_q <= ST_WRITE;
						end
						default: begin
						end
					endcase
				end
				ST_WRITE: begin
					if (!pass_q || out_free) begin
						if (pass_q) begin
							out_valid_q <= 1'b1;
							out_site_q  <= site_q;
							out_x_q     <= r0_q;
							out_y_q     <= r1_q;
							out_z_q     <= r2_q;
							out_last_q  <= (site_q == n_q);
							out_ovf_q   <= sat_q | mov_q;
						end
						sub_q <= '0;
						if (site_q == n_q) begin
							site_q  <= site_t'(1);
							pass_q  <= 1'b1;
							state_q <= pass_q ? ST_IDLE : ST_LOAD;
						end else begin
							site_q  <= site_q + site_t'(1);
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
